[hdl/gasa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gasa_pkg: shared types and constants for the glyph atlas shelf allocator
// Field widths, beat layouts, per-atlas entry record and parameter defaults.
// ----------------------------------------------------------------------------
package gasa_pkg;

    localparam int NUM_ATLASES_DEF = 8;
    localparam int PAD_DEF         = 2;

    localparam int COORD_W   = 12;      // pen, shelf and side fields
    localparam int POS_W     = 11;      // placement corner on the output
    localparam int INDEX_W   = 3;       // atlas index on the output
    localparam int SUM_W     = 14;      // room for pen + padded size

    localparam logic [COORD_W-1:0] SIDE_MAX   = 12'd2048;
    localparam logic [COORD_W-1:0] SIDE_RESET = 12'd512;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam int IN_TDATA_W  = 24;    // rect_width, rect_height
    localparam int IN_TUSER_W  = 1;     // opcode
    localparam int OUT_TDATA_W = 32;    // slot, pos_x, pos_y, opened_new
    localparam int OUT_TUSER_W = 1;     // ok

    typedef struct packed {
        logic [COORD_W-1:0] dim;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] shelf;
    } atlas_entry_t;

    localparam int ENTRY_W = $bits(atlas_entry_t);

endpackage
`default_nettype wire

[hdl/glyph_atlas_shelf_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_allocator: first-fit shelf packing over square atlases
// Pen column, pen row, shelf height and side of each atlas sit in one RAM;
// a sequencer walks the open atlases in order, read-modify-write per atlas.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_*     | in  | tuser: opcode; tdata: rect_width, rect_height
//  m_*     | out | tuser: ok; tdata: slot, pos_x, pos_y, opened_new
//  cfg_*   | in  | atlas_side, written whenever cfg_wr_en is high
//
//  A clear or a zero-sized request goes straight to the result. An allocation
//  visits the open atlases in order, then opens a new atlas if none fits;
//  each visit is a RAM read then a check that writes the entry back if the rectangle fits its side.
//  Reset empties the allocator at once; RAM contents are never cleared.
//  A waiting result sits in the output register while the next beat is taken.
module glyph_atlas_shelf_allocator #(
    parameter int NUM_ATLASES = gasa_pkg::NUM_ATLASES_DEF,
    parameter int PAD         = gasa_pkg::PAD_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gasa_pkg::COORD_W-1:0]    cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [11:0] rect_width, [23:12] rect_height
    input  wire logic [gasa_pkg::IN_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  wire logic [gasa_pkg::IN_TUSER_W-1:0] s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [2:0] slot, [13:3] pos_x, [24:14] pos_y, [25] opened_new, rest 0
    output logic [gasa_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // [0] ok
    output logic [gasa_pkg::OUT_TUSER_W-1:0]     m_tuser
);
    import gasa_pkg::*;

    localparam int AW = (NUM_ATLASES > 1) ? $clog2(NUM_ATLASES) : 1;
    localparam int CW = $clog2(NUM_ATLASES + 1);
    localparam logic [CW-1:0]    N_ATL   = CW'(NUM_ATLASES);
    localparam logic [SUM_W-1:0] PAD_EXT = SUM_W'(PAD);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_OPEN = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      open_count_reg, open_count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [COORD_W-1:0] atlas_side_reg;
    logic [SUM_W-1:0]   pw_reg, pw_next;
    logic [SUM_W-1:0]   ph_reg, ph_next;

    logic               res_ok_reg, res_ok_next;
    logic [INDEX_W-1:0] res_idx_reg, res_idx_next;
    logic [POS_W-1:0]   res_x_reg, res_x_next;
    logic [POS_W-1:0]   res_y_reg, res_y_next;
    logic               res_new_reg, res_new_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;
    logic                   out_load;

    logic               in_accept;
    logic [COORD_W-1:0] in_w, in_h;

    // RAM side
    logic               mem_we, mem_re;
    logic [ENTRY_W-1:0] mem_rdata;
    atlas_entry_t       cur, fresh, upd, wentry;

    // placement datapath
    logic [SUM_W-1:0]   side_ext, col_ext, row_ext, shelf_ext, row1_ext;
    logic               fits_side, wrap, fit;
    logic [COORD_W-1:0] col1, row1, sh1;

    assign in_w      = s_tdata[COORD_W-1:0];
    assign in_h      = s_tdata[2*COORD_W-1:COORD_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign fresh.dim   = (atlas_side_reg > SIDE_MAX) ? SIDE_MAX : atlas_side_reg;
    assign fresh.col   = '0;
    assign fresh.row   = '0;
    assign fresh.shelf = '0;

    assign cur = (state_reg == S_OPEN) ? fresh : atlas_entry_t'(mem_rdata);

    always_comb
    begin
        side_ext  = SUM_W'(cur.dim);
        col_ext   = SUM_W'(cur.col);
        row_ext   = SUM_W'(cur.row);
        shelf_ext = SUM_W'(cur.shelf);
        fits_side = (pw_reg <= side_ext) && (ph_reg <= side_ext);
        wrap      = (col_ext + pw_reg) > side_ext;
        col1      = wrap ? '0 : cur.col;
        row1_ext  = wrap ? (row_ext + shelf_ext) : row_ext;
        row1      = row1_ext[COORD_W-1:0];
        sh1       = wrap ? '0 : cur.shelf;
        fit       = fits_side && ((row1_ext + ph_reg) <= side_ext);

        upd.dim   = cur.dim;
        upd.col   = fit ? (col1 + pw_reg[COORD_W-1:0]) : col1;
        upd.row   = row1;
        upd.shelf = (fit && (ph_reg[COORD_W-1:0] > sh1)) ? ph_reg[COORD_W-1:0] : sh1;

        // an atlas too small for the rectangle keeps its pen
        wentry    = fits_side ? upd : cur;
    end

    assign mem_re = (state_reg == S_RD);
    assign mem_we = (state_reg == S_OPEN) || ((state_reg == S_CHK) && fits_side);

    gasa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ATLASES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (wentry),
        .re    (mem_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        open_count_next = open_count_reg;
        idx_next        = idx_reg;
        pw_next         = pw_reg;
        ph_next         = ph_reg;
        res_ok_next     = res_ok_reg;
        res_idx_next    = res_idx_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_new_next    = res_new_reg;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    pw_next      = SUM_W'(in_w) + PAD_EXT;
                    ph_next      = SUM_W'(in_h) + PAD_EXT;
                    idx_next     = '0;
                    res_ok_next  = 1'b0;
                    res_idx_next = '0;
                    res_x_next   = '0;
                    res_y_next   = '0;
                    res_new_next = 1'b0;
                    if (s_tuser[0] == OP_CLEAR)
                    begin
                        open_count_next = '0;
                        res_ok_next     = 1'b1;
                        state_next      = S_RES;
                    end
                    else if ((in_w == '0) || (in_h == '0))
                    begin
                        state_next = S_RES;
                    end
                    else if (open_count_reg != '0)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_OPEN;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK, S_OPEN:
            begin
                if (state_reg == S_OPEN)
                begin
                    open_count_next = open_count_reg + 1'b1;
                    res_new_next    = 1'b1;
                end
                if (fit)
                begin
                    res_ok_next  = 1'b1;
                    res_idx_next = INDEX_W'(idx_reg);
                    res_x_next   = col1[POS_W-1:0];
                    res_y_next   = row1[POS_W-1:0];
                    state_next   = S_RES;
                end
                else if (state_reg == S_OPEN)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    // idx ends equal to open_count, the slot a new atlas takes
                    idx_next = idx_reg + 1'b1;
                    if ((idx_reg + 1'b1) < open_count_reg)
                    begin
                        state_next = S_RD;
                    end
                    else if (open_count_reg < N_ATL)
                    begin
                        state_next = S_OPEN;
                    end
                    else
                    begin
                        state_next = S_RES;
                    end
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            open_count_reg <= '0;
            atlas_side_reg <= SIDE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            open_count_reg <= open_count_next;
            if (cfg_wr_en)
            begin
                atlas_side_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        pw_reg      <= pw_next;
        ph_reg      <= ph_next;
        res_ok_reg  <= res_ok_next;
        res_idx_reg <= res_idx_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        res_new_reg <= res_new_next;
        if (out_load)
        begin
            out_data_reg <= {6'b0, res_new_reg, res_y_reg, res_x_reg, res_idx_reg};
            out_user_reg <= res_ok_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_count_reg <= N_ATL)
        else $error("open atlas count above limit");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_tuser[0] == OP_CLEAR)) |=> (open_count_reg == '0))
        else $error("clear did not close all atlases");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RD) || (state_reg == S_CHK)) |-> (idx_reg < open_count_reg))
        else $error("walk reached an atlas that is not open");

    a_open_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPEN) |-> ((idx_reg == open_count_reg) && (open_count_reg < N_ATL)))
        else $error("new atlas opened at wrong slot or when full");

    a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !out_load)
        else $error("result overwrote a waiting beat");
`endif

endmodule
`default_nettype wire

[hdl/gasa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gasa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gasa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the glyph atlas shelf allocator
// Drives allocate and clear beats with random gaps and output stalls, predicts
// every result from an in-bench shelf packer and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import gasa_pkg::*;

    localparam int ATLASES = NUM_ATLASES_DEF;
    localparam int PADDING = PAD_DEF;

    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] idx;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic               opened;
    } placement_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [COORD_W-1:0]     cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // [11:0] rect_width, [23:12] rect_height
    logic [IN_TUSER_W-1:0]  s_tuser = '0;     // [0] opcode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // slot, pos_x, pos_y, opened_new
    logic [OUT_TUSER_W-1:0] m_tuser;          // [0] ok

    // packer state as the block should hold it
    logic [COORD_W-1:0] side_reg = SIDE_RESET;
    int                 open_cnt = 0;
    logic [COORD_W-1:0] pen_col_m [ATLASES];
    logic [COORD_W-1:0] pen_row_m [ATLASES];
    logic [COORD_W-1:0] shelf_m   [ATLASES];
    logic [COORD_W-1:0] dim_m     [ATLASES];

    placement_t placement_q[$];
    bit         calm = 1'b0;
    int         mismatches = 0;
    int         n_placed = 0, n_refused = 0, n_clears = 0, n_opened = 0, cfg_writes = 0;

    glyph_atlas_shelf_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("%0t: run timed out", $time);
        $display("== FAIL ==");
        $finish;
    end

    // Shelf placement inside one atlas; the row wrap sticks even if the
    // height check fails afterwards.
    function automatic bit place_in_atlas(input int a, input int pw, input int ph,
                                          output int px, output int py);
        int side;
        side = int'(dim_m[a]);
        px = 0;
        py = 0;
        if (pw > side || ph > side)
            return 1'b0;
        if (int'(pen_col_m[a]) + pw > side)
        begin
            pen_col_m[a] = '0;
            pen_row_m[a] = COORD_W'(int'(pen_row_m[a]) + int'(shelf_m[a]));
            shelf_m[a]   = '0;
        end
        if (int'(pen_row_m[a]) + ph > side)
            return 1'b0;
        px = int'(pen_col_m[a]);
        py = int'(pen_row_m[a]);
        pen_col_m[a] = COORD_W'(px + pw);
        if (ph > int'(shelf_m[a]))
            shelf_m[a] = COORD_W'(ph);
        return 1'b1;
    endfunction

    function automatic placement_t predict_placement(input logic op,
                                                     input logic [COORD_W-1:0] w,
                                                     input logic [COORD_W-1:0] h);
        placement_t r;
        int         pw, ph, a, px, py;
        bit         placed;
        r = '0;
        placed = 1'b0;
        px = 0;
        py = 0;
        if (op == OP_CLEAR)
        begin
            open_cnt = 0;
            r.ok = 1'b1;
            n_clears++;
            return r;
        end
        if (w == '0 || h == '0)
        begin
            n_refused++;
            return r;
        end
        pw = int'(w) + PADDING;
        ph = int'(h) + PADDING;
        for (a = 0; a < open_cnt; a++)
        begin
            if (place_in_atlas(a, pw, ph, px, py))
            begin
                placed = 1'b1;
                break;
            end
        end
        if (!placed && open_cnt < ATLASES)
        begin
            a = open_cnt;
            open_cnt++;
            dim_m[a]     = (side_reg > SIDE_MAX) ? SIDE_MAX : side_reg;
            pen_col_m[a] = '0;
            pen_row_m[a] = '0;
            shelf_m[a]   = '0;
            r.opened = 1'b1;
            n_opened++;
            placed = place_in_atlas(a, pw, ph, px, py);
        end
        if (placed)
        begin
            r.ok  = 1'b1;
            r.idx = INDEX_W'(a);
            r.x   = POS_W'(px);
            r.y   = POS_W'(py);
            n_placed++;
        end
        else
            n_refused++;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] e,
                                        input logic [31:0] a);
        if (e !== a)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        placement_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (placement_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing expected, expected none, got %h/%h",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                e = placement_q.pop_front();
                check_field("ok", 32'(e.ok), 32'(m_tuser[0]));
                check_field("slot", 32'(e.idx), 32'(m_tdata[2:0]));
                check_field("pos_x", 32'(e.x), 32'(m_tdata[13:3]));
                check_field("pos_y", 32'(e.y), 32'(m_tdata[24:14]));
                check_field("opened_new", 32'(e.opened), 32'(m_tdata[25]));
                check_field("tdata pad", 32'd0, 32'(m_tdata[31:26]));
            end
        end
    end

    // receiver: random stall before each result beat
    initial
    begin
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic send_item(input logic op, input logic [COORD_W-1:0] w,
                             input logic [COORD_W-1:0] h);
        int         gap;
        placement_t p;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {h, w};
        do
            @(posedge clk);
        while (!s_tready);
        p = predict_placement(op, w, h);
        placement_q.insert(placement_q.size(), p);
    endtask

    // hold off the sender until every expected result has been taken
    task automatic drain_results(input int extra);
        s_tvalid <= 1'b0;
        while (placement_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_side(input logic [COORD_W-1:0] v);
        drain_results(20);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        side_reg = v;
        cfg_writes++;
    endtask

    function automatic logic [COORD_W-1:0] pick_size(input int room);
        int r;
        r = $urandom_range(0, 99);
        if (room < 1)
            room = 1;
        if (r < 3)
            return '0;
        if (r < 10)
            return COORD_W'($urandom_range(0, 4095));
        if (r < 25)
            return COORD_W'($urandom_range(1, room));
        return COORD_W'($urandom_range(1, (room / 6 > 1) ? room / 6 : 1));
    endfunction

    // zero sizes, oversize, exact fit at the reset side
    task automatic test_size_limits();
        send_item(OP_CLEAR, 12'd4095, 12'd4095);
        send_item(OP_ALLOC, 12'd0, 12'd7);
        send_item(OP_ALLOC, 12'd7, 12'd0);
        send_item(OP_ALLOC, 12'd0, 12'd0);
        send_item(OP_ALLOC, 12'd4095, 12'd4095);   // opens an atlas that cannot hold it
        send_item(OP_ALLOC, 12'd511, 12'd1);       // one pixel too wide once padded
        send_item(OP_ALLOC, 12'd510, 12'd510);     // exact fit in the first atlas
    endtask

    task automatic test_shelf_wrap();
        send_item(OP_ALLOC, 12'd1, 12'd1);         // wraps in a full atlas, then moves on
        send_item(OP_ALLOC, 12'd300, 12'd10);
        send_item(OP_ALLOC, 12'd300, 12'd20);      // new row under the first shelf
    endtask

    task automatic test_atlas_exhaustion();
        repeat (7) send_item(OP_ALLOC, 12'd510, 12'd510);
        send_item(OP_CLEAR, 12'd0, 12'd0);
        send_item(OP_ALLOC, 12'd1, 12'd1);
    endtask

    // side register: zero, one, clamped above 2048; open atlases keep their side
    task automatic test_side_register();
        write_side(12'd0);
        send_item(OP_ALLOC, 12'd600, 12'd600);
        write_side(12'd4095);
        send_item(OP_ALLOC, 12'd2045, 12'd2045);
        send_item(OP_ALLOC, 12'd1000, 12'd1);
        write_side(12'd1);
        send_item(OP_ALLOC, 12'd3000, 12'd1);
    endtask

    task automatic test_random_traffic();
        logic [COORD_W-1:0] side;
        int                 room;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: side = 12'd2048;
                1: side = 12'd64;
                2: side = COORD_W'($urandom_range(1, 2048));
                3: side = 12'd512;
                4: side = COORD_W'($urandom_range(2049, 4095));
                5: side = 12'd16;
                6: side = 12'd1024;
                7: side = COORD_W'($urandom_range(1, 300));
                8: side = 12'd2048;
                default: side = 12'd256;
            endcase
            write_side(side);
            calm = (phase == 3);
            if ($urandom_range(0, 1) == 1)
                send_item(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
            room = (side > SIDE_MAX) ? int'(SIDE_MAX) : int'(side);
            for (int i = 0; i < 190; i++)
            begin
                if (i % 50 == 49 && (phase == 0 || $urandom_range(0, 2) == 0))
                    drain_results(0);
                if ($urandom_range(0, 79) == 0)
                    send_item(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
                else
                    send_item(OP_ALLOC, pick_size(room), pick_size(room));
            end
        end
        calm = 1'b0;
        write_side(SIDE_RESET);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_limits();
        test_shelf_wrap();
        test_atlas_exhaustion();
        test_side_register();
        test_random_traffic();

        drain_results(25);
        $display("Requests: %0d placed, %0d refused, %0d clears, %0d atlases opened",
                 n_placed, n_refused, n_clears, n_opened);
        $display("Atlas side written %0d times, incl. 0, 1, 2048 and sides above 2048",
                 cfg_writes);
        if (mismatches == 0 && placement_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
